// ----- src/exhaustive_word_enumerator_unit_defines.svh -----
// Assertion helpers used by the checker file.
`ifndef EXHAUSTIVE_WORD_ENUMERATOR_UNIT_DEFINES_SVH
`define EXHAUSTIVE_WORD_ENUMERATOR_UNIT_DEFINES_SVH

// Same-cycle implication.
`define EWE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define EWE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/ewe_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ewe_pkg;

  localparam int MAX_WORD_LEN   = 16;
  localparam int ALPHABET_DEPTH = 128;

  localparam int POS_W   = $clog2(MAX_WORD_LEN);
  localparam int DIGIT_W = $clog2(ALPHABET_DEPTH);
  localparam int LEN_W   = 5;
  localparam int RADIX_W = 8;
  localparam int CHAR_W  = 8;
  localparam int IDX_W   = 7;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_SIZE = 2'd2;

  localparam logic [LEN_W-1:0]   MIN_LEN_RST    = 5'd1;
  localparam logic [LEN_W-1:0]   MAX_LEN_RST    = 5'd8;
  localparam logic [RADIX_W-1:0] ALPHA_SIZE_RST = 8'd93;

  typedef enum logic [1:0] {
    MODE_WRITE   = 2'd0,
    MODE_RESTART = 2'd1,
    MODE_NEXT    = 2'd2
  } mode_e;

  typedef struct packed {
    logic [1:0]        mode;
    logic [IDX_W-1:0]  entry_index;
    logic [CHAR_W-1:0] entry_char;
  } ewe_in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_out;
    logic [3:0]        char_position;
    logic [LEN_W-1:0]  word_length;
    logic              last_char;
    logic              exhausted;
  } ewe_out_t;

  // Power-up alphabet, first character in the top byte.
  localparam int DEFAULT_LEN = 93;
  localparam logic [8*DEFAULT_LEN-1:0] DEFAULT_SET =
    "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ 0123456789-_.,+:;!\"$%^&*()[]{}@#~'?/\\<>|";

  function automatic logic [CHAR_W-1:0] default_char(input logic [DIGIT_W-1:0] i);
    logic [CHAR_W-1:0] c;
    c = '0;
    if (int'(i) < DEFAULT_LEN) c = DEFAULT_SET[8*(DEFAULT_LEN-1-int'(i)) +: 8];
    return c;
  endfunction

  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
    logic [LEN_W-1:0] r;
    r = v;
    if (v == '0) r = LEN_W'(1);
    else if (int'(v) > MAX_WORD_LEN) r = LEN_W'(MAX_WORD_LEN);
    return r;
  endfunction

  function automatic logic [RADIX_W-1:0] radix_of(input logic [RADIX_W-1:0] a);
    logic [RADIX_W-1:0] r;
    r = a;
    if (a == '0) r = RADIX_W'(1);
    else if (int'(a) > ALPHABET_DEPTH) r = RADIX_W'(ALPHABET_DEPTH);
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- src/exhaustive_word_enumerator_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Exhaustive word enumerator.
// Command channel: an item is taken on a clock edge with start high and busy low.
//   mode write stores entry_char at alphabet slot entry_index (no beat).
//   mode restart re-arms the enumeration (no beat).
//   mode next emits the current word, one character beat per cycle on res_o,
//   leftmost first, last_char on the final beat, or one exhausted beat.
// Result channel: res_valid_o marks each beat for exactly one cycle; the
//   receiver cannot stall it.
// Next request: one ST_ADV step per digit position visited by the carry
//   (read-modify-write on the digit RAM), then ST_EMIT; each character passes
//   the digit RAM read, the alphabet RAM read and the result register, one beat per cycle.
//   The last beat shows in the first idle cycle.
// Config port: cfg_we_i writes register cfg_index_i at once; write only while idle, unchecked.
// Reset: digits clear, enumeration not started, alphabet back to its
//   93-character default set, min 1, max 8, radix 93.
module exhaustive_word_enumerator_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  ewe_pkg::ewe_in_t                    in_i,
  input  logic                                cfg_we_i,
  input  logic [ewe_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [ewe_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  output logic                                res_valid_o,
  output ewe_pkg::ewe_out_t                   res_o
);
  import ewe_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ADV  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic               done_q, done_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [LEN_W-1:0]   cnt_q, cnt_d;

  logic [LEN_W-1:0]   min_len_q, max_len_q;
  logic [RADIX_W-1:0] alpha_size_q;

  logic [DIGIT_W-1:0]       dig_mem [MAX_WORD_LEN];
  logic [MAX_WORD_LEN-1:0]  dig_vld_q, dig_vld_d;
  logic [DIGIT_W-1:0]       dig_rd_q;
  logic                     dig_rd_vld_q;
  logic [POS_W-1:0]         dig_raddr;
  logic                     dig_we;
  logic [DIGIT_W-1:0]       dig_wdata;

  logic [CHAR_W-1:0]         alpha_mem [ALPHABET_DEPTH];
  logic [ALPHABET_DEPTH-1:0] alpha_vld_q, alpha_vld_d;
  logic [CHAR_W-1:0]         alpha_rd_q, alpha_dflt_q;
  logic                      alpha_rd_vld_q;
  logic                      alpha_we;

  logic               s1_vld_q, s1_vld_d, s1_last_q, s1_last_d;
  logic [POS_W-1:0]   s1_pos_q, s1_pos_d;
  logic               s2_vld_q, s2_last_q;
  logic [POS_W-1:0]   s2_pos_q;

  logic               res_vld_q, res_vld_d;
  ewe_out_t           res_q, res_d;

  logic               accept, exh;
  logic [DIGIT_W-1:0] digit;
  logic [RADIX_W-1:0] inc, radix;
  logic [LEN_W-1:0]   next_len, len_m1, cnt_p1;

  assign busy     = (state_q != ST_IDLE) | s1_vld_q | s2_vld_q;
  assign accept   = start & ~busy;
  assign digit    = dig_rd_vld_q ? dig_rd_q : '0;
  assign inc      = RADIX_W'(digit) + RADIX_W'(1);
  assign radix    = radix_of(alpha_size_q);
  assign next_len = len_q + LEN_W'(1);
  assign len_m1   = len_q - LEN_W'(1);
  assign cnt_p1   = cnt_q + LEN_W'(1);

  always_comb begin
    case (state_q)
      ST_ADV:  dig_raddr = pos_q - POS_W'(1);
      ST_EMIT: dig_raddr = cnt_q[POS_W-1:0];
      default: dig_raddr = len_m1[POS_W-1:0];
    endcase
  end

  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    done_d      = done_q;
    pos_d       = pos_q;
    cnt_d       = cnt_q;
    dig_vld_d   = dig_vld_q;
    alpha_vld_d = alpha_vld_q;
    dig_we      = 1'b0;
    dig_wdata   = inc[DIGIT_W-1:0];
    alpha_we    = 1'b0;
    s1_vld_d    = 1'b0;
    s1_pos_d    = cnt_q[POS_W-1:0];
    s1_last_d   = (cnt_p1 == len_q);
    exh         = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_i.mode)
            MODE_WRITE: begin
              alpha_we = 1'b1;
              alpha_vld_d[in_i.entry_index] = 1'b1;
            end
            MODE_RESTART: begin
              dig_vld_d = '0;
              len_d     = '0;
              done_d    = 1'b0;
            end
            MODE_NEXT: begin
              if (done_q) begin
                exh = 1'b1;
              end else if (len_q == '0) begin
                len_d     = clamp_len(min_len_q);
                dig_vld_d = '0;
                cnt_d     = '0;
                state_d   = ST_EMIT;
              end else begin
                pos_d   = len_m1[POS_W-1:0];
                state_d = ST_ADV;
              end
            end
            default: ;
          endcase
        end
      end
      ST_ADV: begin
        // digit for pos_q is in the read register; the next read is pos_q-1
        dig_we = 1'b1;
        dig_vld_d[pos_q] = 1'b1;
        if (inc < radix) begin
          cnt_d   = '0;
          state_d = ST_EMIT;
        end else begin
          dig_wdata = '0;
          if (pos_q == '0) begin
            if (next_len > clamp_len(max_len_q) || next_len > LEN_W'(MAX_WORD_LEN)) begin
              done_d  = 1'b1;
              exh     = 1'b1;
              state_d = ST_IDLE;
            end else begin
              len_d     = next_len;
              dig_vld_d = '0;
              cnt_d     = '0;
              state_d   = ST_EMIT;
            end
          end else begin
            pos_d = pos_q - POS_W'(1);
          end
        end
      end
      ST_EMIT: begin
        s1_vld_d = 1'b1;
        cnt_d    = cnt_p1;
        if (cnt_p1 == len_q) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    res_vld_d           = s2_vld_q | exh;
    res_d.char_out      = alpha_rd_vld_q ? alpha_rd_q : alpha_dflt_q;
    res_d.char_position = s2_pos_q;
    res_d.word_length   = len_q;
    res_d.last_char     = s2_last_q;
    res_d.exhausted     = 1'b0;
    if (exh) begin
      res_d = '0;
      res_d.last_char = 1'b1;
      res_d.exhausted = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      len_q        <= '0;
      done_q       <= 1'b0;
      pos_q        <= '0;
      cnt_q        <= '0;
      dig_vld_q    <= '0;
      alpha_vld_q  <= '0;
      s1_vld_q     <= 1'b0;
      s2_vld_q     <= 1'b0;
      res_vld_q    <= 1'b0;
      min_len_q    <= MIN_LEN_RST;
      max_len_q    <= MAX_LEN_RST;
      alpha_size_q <= ALPHA_SIZE_RST;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      done_q      <= done_d;
      pos_q       <= pos_d;
      cnt_q       <= cnt_d;
      dig_vld_q   <= dig_vld_d;
      alpha_vld_q <= alpha_vld_d;
      s1_vld_q    <= s1_vld_d;
      s2_vld_q    <= s1_vld_q;
      res_vld_q   <= res_vld_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_MIN_LEN:    min_len_q    <= cfg_data_i[LEN_W-1:0];
          CFG_MAX_LEN:    max_len_q    <= cfg_data_i[LEN_W-1:0];
          CFG_ALPHA_SIZE: alpha_size_q <= cfg_data_i[RADIX_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    s1_pos_q  <= s1_pos_d;
    s1_last_q <= s1_last_d;
    s2_pos_q  <= s1_pos_q;
    s2_last_q <= s1_last_q;
    res_q     <= res_d;
  end

  // digit RAM: one write, one read per cycle
  always_ff @(posedge clk_i) begin
    if (dig_we) dig_mem[pos_q] <= dig_wdata;
    dig_rd_q     <= dig_mem[dig_raddr];
    dig_rd_vld_q <= dig_vld_q[dig_raddr];
  end

  // alphabet RAM; slots never written read as the default set
  always_ff @(posedge clk_i) begin
    if (alpha_we) alpha_mem[in_i.entry_index] <= in_i.entry_char;
    alpha_rd_q     <= alpha_mem[digit];
    alpha_rd_vld_q <= alpha_vld_q[digit];
    alpha_dflt_q   <= default_char(digit);
  end

  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

// ----- src/ewe_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "exhaustive_word_enumerator_unit_defines.svh"

module ewe_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           start,
  input logic                           busy,
  input ewe_pkg::ewe_in_t               in_i,
  input logic                           res_valid_o,
  input ewe_pkg::ewe_out_t              res_o
);
  import ewe_pkg::*;

  `EWE_ASSERT_SAME(a_exh_beat, clk_i, rst_ni, res_valid_o && res_o.exhausted, res_o.last_char && res_o.word_length == '0 && res_o.char_position == '0 && res_o.char_out == '0, "exhausted beat carries data")

  `EWE_ASSERT_SAME(a_char_beat, clk_i, rst_ni, res_valid_o && !res_o.exhausted, res_o.word_length != '0 && res_o.word_length <= LEN_W'(MAX_WORD_LEN) && LEN_W'(res_o.char_position) < res_o.word_length && res_o.last_char == (LEN_W'(res_o.char_position) + LEN_W'(1) == res_o.word_length), "character beat fields inconsistent")

  `EWE_ASSERT_NEXT(a_word_run, clk_i, rst_ni, res_valid_o && !res_o.last_char, res_valid_o && res_o.char_position == $past(res_o.char_position) + 4'd1 && $stable(res_o.word_length), "word beats not back to back")

  `EWE_ASSERT_NEXT(a_no_beat, clk_i, rst_ni, start && !busy && in_i.mode != MODE_NEXT, !res_valid_o, "beat after a silent command")

endmodule

bind exhaustive_word_enumerator_unit ewe_checker u_ewe_checker (.*);

`default_nettype wire
